/* src/smq_pkg.sv */
package smq_pkg;

    // Number of entries the store can hold.
    localparam int CAPACITY = 16;

    // Width of the internal entry counter: it must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Field widths of the stream payloads.
    localparam int OP_W          = 2;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Request codes carried in the input tuser field.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // Response codes carried in the output tuser field.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_SEND
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the request on an input transfer
        logic exec;   // apply the captured request to the store
    } smq_cmd_t;

endpackage

/* src/sorted_min_queue_unit.sv */
// Channel   Direction  tdata (low bit up)                    tuser
// s_*       in         value[31:0]                           op[1:0]
// m_*       out        popped_value[31:0], entry_count[36:32] status[1:0]
//
// Each request is captured, then every cell compares and shifts in parallel
// in the execute state, then the response is offered.
// One request is handled at a time; the next is taken once the response
// has been transferred, so a stalled output also holds off the input.
// Reset clears the entry count at once; there is no clearing pass.
module sorted_min_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // popped_value[31:0], entry_count[36:32], zeros
    output logic [1:0]  m_tuser    // status[1:0]
);
    import smq_pkg::*;

    smq_cmd_t                  cmd;
    logic signed [VALUE_W-1:0] popped_value;
    logic [ENTRY_COUNT_W-1:0]  entry_count;

    // Sequencing of transfers and execution.
    smq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Sorted store and response registers.
    smq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (s_tuser),
        .value        (s_tdata),
        .status       (m_tuser),
        .popped_value (popped_value),
        .entry_count  (entry_count)
    );

    assign m_tdata = {3'b000, entry_count, popped_value};

    // The block never takes a request while a response is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input ready while a response is pending");

    // A request transfer is followed by the execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
        else $error("execute cycle skipped after a request transfer");

    // A dropped insert reports a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[36:32] == ENTRY_COUNT_W'(CAPACITY)))
        else $error("full status with a count below capacity");

    // Only a successful request may carry a popped value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[31:0] == '0))
        else $error("popped value on a failed request");

endmodule

/* src/smq_ctrl.sv */
module smq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output smq_pkg::smq_cmd_t cmd
);
    import smq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = CTL_SEND;
            end
            CTL_SEND:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

/* src/smq_datapath.sv */
module smq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smq_pkg::smq_cmd_t                 cmd,
    input  logic [smq_pkg::OP_W-1:0]          op,
    input  logic signed [smq_pkg::VALUE_W-1:0] value,
    output logic [smq_pkg::STATUS_W-1:0]      status,
    output logic signed [smq_pkg::VALUE_W-1:0] popped_value,
    output logic [smq_pkg::ENTRY_COUNT_W-1:0] entry_count
);
    import smq_pkg::*;

    logic [OP_W-1:0]           op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] entry_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] entry_next [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [VALUE_W-1:0] popped_reg;
    logic signed [VALUE_W-1:0] popped_next;

    // Per-cell comparison results.
    logic [CAPACITY-1:0] keep;    // occupied and smaller than the request value
    logic [CAPACITY-1:0] match;   // occupied and equal to the request value
    logic [CAPACITY-1:0] seen;    // a match lies at or below this cell
    logic                is_full;
    logic                is_empty;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Every cell compares its own entry with the request value.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i]  = (CNT_W'(i) < count_reg) && (entry_reg[i] < value_reg);
            match[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] == value_reg);
        end
        seen[0] = match[0];
        for (int i = 1; i < CAPACITY; i++)
        begin
            seen[i] = seen[i-1] | match[i];
        end
    end

    // Next contents of the store and the response fields.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        count_next  = count_reg;
        status_next = STAT_OK;
        popped_next = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    // Cells at and above the insert point move up by one.
                    entry_next[0] = keep[0] ? entry_reg[0] : value_reg;
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (keep[i])
                        begin
                            entry_next[i] = entry_reg[i];
                        end
                        else if (keep[i-1])
                        begin
                            entry_next[i] = value_reg;
                        end
                        else
                        begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    popped_next = entry_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        entry_next[i] = entry_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (!seen[CAPACITY-1])
                begin
                    status_next = STAT_NOTFOUND;
                end
                else
                begin
                    // Cells from the first match upward take their upper neighbour.
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (seen[i])
                        begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Request capture and store contents; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    // Entry counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = ENTRY_COUNT_W'(count_reg);

endmodule
